### rtl/rv64_dec_pkg.sv
// Package for the RV64I instruction decoder: opcodes, field codes and the
// decoded bundle type. No dependencies.
`default_nettype none

package rv64_dec_pkg;

   // Major opcodes (instruction bits 6:0)
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   // funct7 / funct6 patterns selecting SUB and SRA
   localparam logic [6:0] FUNCT7_ALT = 7'b0100000;
   localparam logic [5:0] FUNCT6_ALT = 6'b010000;

   // funct3 codes that matter outside the table lookups
   localparam logic [2:0] F3_ADD  = 3'b000;
   localparam logic [2:0] F3_SLL  = 3'b001;
   localparam logic [2:0] F3_SLT  = 3'b010;
   localparam logic [2:0] F3_SLTU = 3'b011;
   localparam logic [2:0] F3_XOR  = 3'b100;
   localparam logic [2:0] F3_SR   = 3'b101;
   localparam logic [2:0] F3_OR   = 3'b110;
   localparam logic [2:0] F3_AND  = 3'b111;

   // ALU operation codes
   localparam logic [3:0] ALU_ADD  = 4'd0;
   localparam logic [3:0] ALU_SUB  = 4'd1;
   localparam logic [3:0] ALU_SLL  = 4'd2;
   localparam logic [3:0] ALU_SLT  = 4'd3;
   localparam logic [3:0] ALU_SLTU = 4'd4;
   localparam logic [3:0] ALU_XOR  = 4'd5;
   localparam logic [3:0] ALU_SRL  = 4'd6;
   localparam logic [3:0] ALU_SRA  = 4'd7;
   localparam logic [3:0] ALU_OR   = 4'd8;
   localparam logic [3:0] ALU_AND  = 4'd9;
   localparam logic [3:0] ALU_PASS = 4'd10;

   // Write-back source
   localparam logic [1:0] WB_ALU = 2'd0;
   localparam logic [1:0] WB_MEM = 2'd1;
   localparam logic [1:0] WB_PC4 = 2'd2;

   // Memory access kind
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LOAD  = 2'd1;
   localparam logic [1:0] MEM_STORE = 2'd2;

   // Access size
   localparam logic [2:0] SIZE_BYTE = 3'd0;
   localparam logic [2:0] SIZE_WORD = 3'd2;

   // Next-PC source
   localparam logic [1:0] NPC_SEQ    = 2'd0;
   localparam logic [1:0] NPC_BRANCH = 2'd1;
   localparam logic [1:0] NPC_JAL    = 2'd2;
   localparam logic [1:0] NPC_JALR   = 2'd3;

   // Trap kind
   localparam logic [1:0] EXC_NONE   = 2'd0;
   localparam logic [1:0] EXC_ECALL  = 2'd1;
   localparam logic [1:0] EXC_EBREAK = 2'd2;

   typedef struct packed {
      logic signed [63:0] immediate_value;
      logic [3:0]         alu_operation;
      logic               operand_a_is_pc;
      logic               operand_b_is_imm;
      logic [1:0]         writeback_source;
      logic               register_write;
      logic [1:0]         mem_kind;
      logic [2:0]         access_size;
      logic [1:0]         next_pc_source;
      logic [1:0]         trap_kind;
   } decode_type;

   // Register-register / register-immediate ALU op from funct3
   function automatic logic [3:0] arith_op(input logic [2:0] f3,
                                           input logic alt_sub,
                                           input logic alt_shift);
      logic [3:0] op;
      case (f3)
         F3_ADD:  op = alt_sub ? ALU_SUB : ALU_ADD;
         F3_SLL:  op = ALU_SLL;
         F3_SLT:  op = ALU_SLT;
         F3_SLTU: op = ALU_SLTU;
         F3_XOR:  op = ALU_XOR;
         F3_SR:   op = alt_shift ? ALU_SRA : ALU_SRL;
         F3_OR:   op = ALU_OR;
         default: op = ALU_AND;
      endcase
      return op;
   endfunction

   // Branch compare op: BEQ/BNE subtract, signed and unsigned compares otherwise
   function automatic logic [3:0] branch_op(input logic [2:0] f3);
      logic [3:0] op;
      case (f3)
         F3_ADD, F3_SLL:  op = ALU_SUB;
         F3_SLTU, F3_OR, F3_AND: op = ALU_SLTU;
         default:         op = ALU_SLT;
      endcase
      return op;
   endfunction

   // Load/store size; the reserved funct3 of all ones reads as word
   function automatic logic [2:0] access_size_of(input logic [2:0] f3);
      return (f3 == F3_AND) ? SIZE_WORD : f3;
   endfunction

endpackage

`default_nettype wire

### rtl/rv64i_instruction_decoder.sv
// RV64I instruction decoder top level: input register, decode logic and
// result register. Depends on rv64_dec_pkg.
`default_nettype none

// Decodes one 32-bit RV64I instruction per transaction into the control
// bundle a simple core needs: sign-extended 64-bit immediate (I, S, B, U, J
// formats; zero for R-type and unknown opcodes), ALU operation, operand
// selects, write-back source and register-write flag, load/store kind and
// size, next-PC source and ECALL/EBREAK detection. SYSTEM instructions use the
// I-type immediate, so an immediate of 0 flags ecall and 1 flags ebreak;
// SRAI is recognised on bits 31:26 so shamt[5] is free. Register indices are
// plain bit slices and are left to the caller. Throughput is one transaction
// per clock while rsp_ready keeps the result moving. The accepting edge on req
// captures the word in the input register; the decode logic sits between it
// and the result register, which loads once it is empty or being taken, and
// rsp_valid rises when it loads. The input register frees only when empty or
// when its word moves on, so it can accept while a finished result waits for
// rsp_ready; with the result stalled the block can hold one further transaction
// before req_ready drops.
// There is no configuration and no state beyond the pipeline.
module rv64i_instruction_decoder
   import rv64_dec_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [31:0]        req_instruction_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [63:0]      rsp_immediate_value,
   output logic [3:0]              rsp_alu_operation,
   output logic                    rsp_operand_a_is_pc,
   output logic                    rsp_operand_b_is_imm,
   output logic [1:0]              rsp_writeback_source,
   output logic                    rsp_register_write,
   output logic [1:0]              rsp_mem_kind,
   output logic [2:0]              rsp_access_size,
   output logic [1:0]              rsp_next_pc_source,
   output logic [1:0]              rsp_trap_kind
);

   // Input stage
   logic [31:0] instr_ff;
   logic        instr_valid_ff;
   logic        instr_valid_in;

   // Result stage
   decode_type  result_ff;
   decode_type  result_in;
   logic        result_valid_ff;
   logic        result_valid_in;

   logic        result_load;   // result register takes a new decode
   logic        instr_load;    // input register takes a new transaction

   // Field slices of the registered instruction
   logic [6:0]  opcode;
   logic [2:0]  funct3;
   logic [6:0]  funct7;
   logic [5:0]  funct6;
   logic signed [63:0] imm_i;
   logic signed [63:0] imm_s;
   logic signed [63:0] imm_b;
   logic signed [63:0] imm_u;
   logic signed [63:0] imm_j;

   // ---------------------------------------------------------------------
   // Handshake: result register frees when empty or being taken; the input
   // register frees when empty or when its content moves to the result.
   // ---------------------------------------------------------------------
   assign result_load = instr_valid_ff && (!result_valid_ff || rsp_ready);
   assign req_ready   = !instr_valid_ff || result_load;
   assign instr_load  = req_valid && req_ready;

   always_comb begin
      instr_valid_in = instr_valid_ff;
      if (instr_load) begin
         instr_valid_in = 1'b1;
      end else if (result_load) begin
         instr_valid_in = 1'b0;
      end
   end

   always_comb begin
      result_valid_in = result_valid_ff;
      if (result_load) begin
         result_valid_in = 1'b1;
      end else if (rsp_ready) begin
         result_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Immediate formats
   // ---------------------------------------------------------------------
   assign opcode = instr_ff[6:0];
   assign funct3 = instr_ff[14:12];
   assign funct7 = instr_ff[31:25];
   assign funct6 = instr_ff[31:26];

   assign imm_i = {{52{instr_ff[31]}}, instr_ff[31:20]};
   assign imm_s = {{52{instr_ff[31]}}, instr_ff[31:25], instr_ff[11:7]};
   assign imm_b = {{51{instr_ff[31]}}, instr_ff[31], instr_ff[7],
                   instr_ff[30:25], instr_ff[11:8], 1'b0};
   assign imm_u = {{32{instr_ff[31]}}, instr_ff[31:12], 12'b0};
   assign imm_j = {{43{instr_ff[31]}}, instr_ff[31], instr_ff[19:12],
                   instr_ff[20], instr_ff[30:21], 1'b0};

   // ---------------------------------------------------------------------
   // Decode. Defaults describe an unknown opcode: everything off, add, zero.
   // ---------------------------------------------------------------------
   always_comb begin
      result_in                  = '0;
      result_in.alu_operation    = ALU_ADD;
      result_in.writeback_source = WB_ALU;
      result_in.mem_kind         = MEM_NONE;
      result_in.access_size      = SIZE_BYTE;
      result_in.next_pc_source   = NPC_SEQ;
      result_in.trap_kind        = EXC_NONE;
      unique case (opcode)
         OPC_OP: begin
            result_in.register_write = 1'b1;
            result_in.alu_operation  = arith_op(funct3, funct7 == FUNCT7_ALT,
                                                funct7 == FUNCT7_ALT);
         end
         OPC_OPIMM: begin
            result_in.immediate_value  = imm_i;
            result_in.operand_b_is_imm = 1'b1;
            result_in.register_write   = 1'b1;
            result_in.alu_operation    = arith_op(funct3, 1'b0, funct6 == FUNCT6_ALT);
         end
         OPC_LOAD: begin
            result_in.immediate_value  = imm_i;
            result_in.writeback_source = WB_MEM;
            result_in.operand_b_is_imm = 1'b1;
            result_in.register_write   = 1'b1;
            result_in.mem_kind         = MEM_LOAD;
            result_in.access_size      = access_size_of(funct3);
         end
         OPC_STORE: begin
            // stores report memory write-back but never write a register
            result_in.immediate_value  = imm_s;
            result_in.writeback_source = WB_MEM;
            result_in.operand_b_is_imm = 1'b1;
            result_in.mem_kind         = MEM_STORE;
            result_in.access_size      = access_size_of(funct3);
         end
         OPC_BRANCH: begin
            result_in.immediate_value = imm_b;
            result_in.next_pc_source  = NPC_BRANCH;
            result_in.alu_operation   = branch_op(funct3);
         end
         OPC_LUI: begin
            result_in.immediate_value  = imm_u;
            result_in.operand_a_is_pc  = 1'b1;
            result_in.operand_b_is_imm = 1'b1;
            result_in.register_write   = 1'b1;
            result_in.alu_operation    = ALU_PASS;
         end
         OPC_AUIPC: begin
            result_in.immediate_value  = imm_u;
            result_in.operand_a_is_pc  = 1'b1;
            result_in.operand_b_is_imm = 1'b1;
            result_in.register_write   = 1'b1;
         end
         OPC_JAL: begin
            result_in.immediate_value  = imm_j;
            result_in.writeback_source = WB_PC4;
            result_in.register_write   = 1'b1;
            result_in.next_pc_source   = NPC_JAL;
         end
         OPC_JALR: begin
            result_in.immediate_value  = imm_i;
            result_in.writeback_source = WB_PC4;
            result_in.operand_b_is_imm = 1'b1;
            result_in.register_write   = 1'b1;
            result_in.next_pc_source   = NPC_JALR;
         end
         OPC_SYSTEM: begin
            // trap kind depends on the 12-bit immediate only
            result_in.immediate_value  = imm_i;
            result_in.operand_b_is_imm = 1'b1;
            result_in.alu_operation    = ALU_PASS;
            if (instr_ff[31:20] == 12'd0) begin
               result_in.trap_kind = EXC_ECALL;
            end else if (instr_ff[31:20] == 12'd1) begin
               result_in.trap_kind = EXC_EBREAK;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         instr_valid_ff  <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         instr_valid_ff  <= instr_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (instr_load) begin
         instr_ff <= req_instruction_word;
      end
      if (result_load) begin
         result_ff <= result_in;
      end
   end

   // ---------------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------------
   assign rsp_valid            = result_valid_ff;
   assign rsp_immediate_value  = result_ff.immediate_value;
   assign rsp_alu_operation    = result_ff.alu_operation;
   assign rsp_operand_a_is_pc  = result_ff.operand_a_is_pc;
   assign rsp_operand_b_is_imm = result_ff.operand_b_is_imm;
   assign rsp_writeback_source = result_ff.writeback_source;
   assign rsp_register_write   = result_ff.register_write;
   assign rsp_mem_kind         = result_ff.mem_kind;
   assign rsp_access_size      = result_ff.access_size;
   assign rsp_next_pc_source   = result_ff.next_pc_source;
   assign rsp_trap_kind        = result_ff.trap_kind;

endmodule

`default_nettype wire

### rtl/rv64_dec_checker.sv
// Port-level checker for the RV64I instruction decoder and its bind.
// Depends on rv64_dec_pkg and rv64i_instruction_decoder.
`default_nettype none

module rv64_dec_checker
   import rv64_dec_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [63:0] rsp_immediate_value,
   input wire logic [3:0]         rsp_alu_operation,
   input wire logic [1:0]         rsp_writeback_source,
   input wire logic               rsp_register_write,
   input wire logic [1:0]         rsp_mem_kind,
   input wire logic [1:0]         rsp_next_pc_source,
   input wire logic [1:0]         rsp_trap_kind
);

   // a stalled transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_immediate_value)
                                 && $stable(rsp_alu_operation))
      else $error("rsp payload changed while stalled");

   // stores never write a register
   a_store_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_kind == MEM_STORE |-> !rsp_register_write)
      else $error("store flagged with register write");

   // traps only on SYSTEM: no jump, no memory, no write, immediate 0 or 1
   a_trap_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trap_kind != EXC_NONE |->
         rsp_next_pc_source == NPC_SEQ && rsp_mem_kind == MEM_NONE &&
         !rsp_register_write && rsp_alu_operation == ALU_PASS &&
         (rsp_immediate_value == 64'sd0 || rsp_immediate_value == 64'sd1))
      else $error("trap decoded alongside other effects");

   // PC+4 write-back belongs to jumps only
   a_link_is_jump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_writeback_source == WB_PC4 |->
         rsp_register_write &&
         (rsp_next_pc_source == NPC_JAL || rsp_next_pc_source == NPC_JALR))
      else $error("link write-back without a jump");

   // an empty pipeline always takes a new transaction
   a_ready_after_drain: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(req_valid && req_ready) |-> req_ready)
      else $error("req_ready low with nothing in flight");

endmodule

bind rv64i_instruction_decoder rv64_dec_checker u_rv64_dec_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_immediate_value  (rsp_immediate_value),
   .rsp_alu_operation    (rsp_alu_operation),
   .rsp_writeback_source (rsp_writeback_source),
   .rsp_register_write   (rsp_register_write),
   .rsp_mem_kind         (rsp_mem_kind),
   .rsp_next_pc_source   (rsp_next_pc_source),
   .rsp_trap_kind        (rsp_trap_kind)
);

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
// Testbench for rv64i_instruction_decoder: directed and random instruction words,
// each checked field by field against a behavioural decoder here or a table decode.
// Depends on rv64_dec_pkg and the decoder RTL only.

module tb;
   import rv64_dec_pkg::*;

   // Stimulus row: instruction word, whether the expected decode is written out
   // by hand in the table, and that hand-written decode (unused otherwise).
   typedef struct packed {
      logic [31:0] word;
      logic        literal;
      decode_type  result;
   } stim_row_type;

   localparam logic PREDICTED = 1'b0;
   localparam logic LITERAL   = 1'b1;
   localparam decode_type BLANK_DECODE = '0;

   localparam int unsigned RANDOM_WORDS    = 1250;
   localparam int unsigned HOLD_OFF_AT     = 300;   // words accepted before the long rsp stall
   localparam int unsigned HOLD_OFF_CYCLES = 80;
   localparam int unsigned DRAIN_AT        = 700;   // random word after which the sender drains
   localparam int unsigned SETTLE_CYCLES   = 8;     // margin for the last decodes to return

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_instruction_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;

   logic signed [63:0] rsp_immediate_value;
   logic [3:0]         rsp_alu_operation;
   logic               rsp_operand_a_is_pc;
   logic               rsp_operand_b_is_imm;
   logic [1:0]         rsp_writeback_source;
   logic               rsp_register_write;
   logic [1:0]         rsp_mem_kind;
   logic [2:0]         rsp_access_size;
   logic [1:0]         rsp_next_pc_source;
   logic [1:0]         rsp_trap_kind;

   // Expected decode travels alongside the word, held stable with the payload
   decode_type  req_decode = '0;

   stim_row_type directed_table[$];
   stim_row_type pending_decodes[$];
   int unsigned words_accepted = 0;
   int unsigned decodes_in_flight = 0;
   int unsigned errors = 0;

   rv64i_instruction_decoder u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_instruction_word (req_instruction_word),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_immediate_value  (rsp_immediate_value),
      .rsp_alu_operation    (rsp_alu_operation),
      .rsp_operand_a_is_pc  (rsp_operand_a_is_pc),
      .rsp_operand_b_is_imm (rsp_operand_b_is_imm),
      .rsp_writeback_source (rsp_writeback_source),
      .rsp_register_write   (rsp_register_write),
      .rsp_mem_kind         (rsp_mem_kind),
      .rsp_access_size      (rsp_access_size),
      .rsp_next_pc_source   (rsp_next_pc_source),
      .rsp_trap_kind        (rsp_trap_kind)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Generous ceiling: several times the slowest legal run
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Behavioural decoder
   // ------------------------------------------------------------------

   // funct3 to ALU op for OP / OP-IMM before the SUB / SRA overrides
   function automatic logic [3:0] arith_from_funct3(input logic [2:0] f3);
      case (f3)
         F3_ADD:  return ALU_ADD;
         F3_SLL:  return ALU_SLL;
         F3_SLT:  return ALU_SLT;
         F3_SLTU: return ALU_SLTU;
         F3_XOR:  return ALU_XOR;
         F3_SR:   return ALU_SRL;
         F3_OR:   return ALU_OR;
         default: return ALU_AND;
      endcase
   endfunction

   function automatic decode_type decode_word(input logic [31:0] w);
      decode_type d;
      logic [6:0] opcode;
      logic [2:0] f3;
      logic       alt7;
      logic       alt6;
      opcode = w[6:0];
      f3     = w[14:12];
      alt7   = (w[31:25] == FUNCT7_ALT);
      alt6   = (w[31:26] == FUNCT6_ALT);
      d      = BLANK_DECODE;

      // immediate by format
      case (opcode)
         OPC_LOAD, OPC_OPIMM, OPC_JALR, OPC_SYSTEM:
            d.immediate_value = {{52{w[31]}}, w[31:20]};
         OPC_STORE:
            d.immediate_value = {{52{w[31]}}, w[31:25], w[11:7]};
         OPC_BRANCH:
            d.immediate_value = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         OPC_LUI, OPC_AUIPC:
            d.immediate_value = {{32{w[31]}}, w[31:12], 12'h000};
         OPC_JAL:
            d.immediate_value = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         default:
            d.immediate_value = '0;
      endcase

      case (opcode)
         OPC_OP: begin
            d.register_write = 1'b1;
            d.alu_operation  = arith_from_funct3(f3);
            if (f3 == F3_ADD && alt7) d.alu_operation = ALU_SUB;
            if (f3 == F3_SR && alt7)  d.alu_operation = ALU_SRA;
         end
         OPC_OPIMM: begin
            d.operand_b_is_imm = 1'b1;
            d.register_write   = 1'b1;
            d.alu_operation    = arith_from_funct3(f3);
            // RV64: shamt is six bits, so SRAI is told apart on bits 31:26
            if (f3 == F3_SR && alt6) d.alu_operation = ALU_SRA;
         end
         OPC_LOAD, OPC_STORE: begin
            d.operand_b_is_imm = 1'b1;
            d.writeback_source = WB_MEM;   // stores report memory too
            d.register_write   = (opcode == OPC_LOAD);
            d.mem_kind         = (opcode == OPC_LOAD) ? MEM_LOAD : MEM_STORE;
            d.access_size      = (f3 == F3_AND) ? SIZE_WORD : f3;
         end
         OPC_BRANCH: begin
            d.next_pc_source = NPC_BRANCH;
            case (f3)
               F3_ADD, F3_SLL:      d.alu_operation = ALU_SUB;
               F3_SLT, F3_XOR, F3_SR: d.alu_operation = ALU_SLT;
               default:             d.alu_operation = ALU_SLTU;
            endcase
         end
         OPC_LUI: begin
            d.operand_a_is_pc  = 1'b1;
            d.operand_b_is_imm = 1'b1;
            d.register_write   = 1'b1;
            d.alu_operation    = ALU_PASS;
         end
         OPC_AUIPC: begin
            d.operand_a_is_pc  = 1'b1;
            d.operand_b_is_imm = 1'b1;
            d.register_write   = 1'b1;
         end
         OPC_JAL: begin
            d.writeback_source = WB_PC4;
            d.register_write   = 1'b1;
            d.next_pc_source   = NPC_JAL;
         end
         OPC_JALR: begin
            d.writeback_source = WB_PC4;
            d.operand_b_is_imm = 1'b1;
            d.register_write   = 1'b1;
            d.next_pc_source   = NPC_JALR;
         end
         OPC_SYSTEM: begin
            d.operand_b_is_imm = 1'b1;
            d.alu_operation    = ALU_PASS;
            // only the 12-bit immediate matters; rd, funct3, rs1 are don't-care
            if (d.immediate_value == 64'sd0)      d.trap_kind = EXC_ECALL;
            else if (d.immediate_value == 64'sd1) d.trap_kind = EXC_EBREAK;
         end
         default: ;
      endcase
      return d;
   endfunction

   // ------------------------------------------------------------------
   // Random helpers
   // ------------------------------------------------------------------

   // Idle stretch: mostly none or short, now and then long
   function automatic int unsigned idle_length(input int unsigned floor_len);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)      return floor_len;
      else if (r < 92) return floor_len + $urandom_range(1, 3);
      else if (r < 98) return floor_len + $urandom_range(4, 12);
      else             return floor_len + $urandom_range(20, 40);
   endfunction

   // Mostly real opcodes with random upper bits, steered at the corner decodes,
   // plus a share of raw noise (nearly always an unknown opcode)
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 15))
         0:  w[6:0] = OPC_LOAD;
         1:  w[6:0] = OPC_OPIMM;
         2:  w[6:0] = OPC_AUIPC;
         3:  w[6:0] = OPC_STORE;
         4:  w[6:0] = OPC_OP;
         5:  w[6:0] = OPC_LUI;
         6:  w[6:0] = OPC_BRANCH;
         7:  w[6:0] = OPC_JALR;
         8:  w[6:0] = OPC_JAL;
         9:  w[6:0] = OPC_SYSTEM;
         10: begin
            // ecall / ebreak with junk in rd, funct3, rs1
            w[6:0]   = OPC_SYSTEM;
            w[31:21] = '0;
         end
         11: begin
            w[6:0]   = OPC_OP;
            w[14:12] = $urandom_range(0, 1) ? F3_SR : F3_ADD;
            w[31:25] = $urandom_range(0, 1) ? FUNCT7_ALT : 7'b0;
         end
         12: begin
            w[6:0]   = OPC_OPIMM;
            w[14:12] = $urandom_range(0, 1) ? F3_SR : F3_SLL;
            w[31:26] = $urandom_range(0, 1) ? FUNCT6_ALT : 6'b0;
         end
         default: ;
      endcase
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------

   // Present one word until accepted, then maybe leave a gap. Valid is only
   // lowered when a gap follows, so back-to-back transactions keep it high.
   task automatic offer(input logic [31:0] word, input decode_type want, input bit may_idle);
      int unsigned gap;
      req_valid            <= 1'b1;
      req_instruction_word <= word;
      req_decode           <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = may_idle ? idle_length(0) : 0;
      if (gap != 0) begin
         req_valid            <= 1'b0;
         req_instruction_word <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off until every outstanding decode has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decodes_in_flight != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      stim_row_type row;
      logic [31:0]  w;

      // unknown opcodes: nothing decoded
      directed_table.push_back({32'h0000_0000, LITERAL, BLANK_DECODE});
      directed_table.push_back({32'hFFFF_FFFF, LITERAL, BLANK_DECODE});
      // R-type: add, sub, sra, and srl with a funct7 that is not the alternate
      directed_table.push_back({32'h0031_00B3, PREDICTED, BLANK_DECODE});
      directed_table.push_back({32'h4031_00B3, PREDICTED, BLANK_DECODE});
      directed_table.push_back({32'h4031_50B3, PREDICTED, BLANK_DECODE});
      directed_table.push_back({32'h4231_50B3, PREDICTED, BLANK_DECODE});
      // OP-IMM: addi -1, srai 63 (shamt[5] set), sltiu with most negative imm
      directed_table.push_back({32'hFFF0_8093, PREDICTED, BLANK_DECODE});
      directed_table.push_back({32'h43F0_D093, PREDICTED, BLANK_DECODE});
      directed_table.push_back({32'h8000_B093, PREDICTED, BLANK_DECODE});
      // loads: ld -8, reserved funct3 reading as word
      directed_table.push_back({32'hFF81_3083, PREDICTED, BLANK_DECODE});
      directed_table.push_back({32'h0001_F083, PREDICTED, BLANK_DECODE});
      // stores: sd -1, sb +2047
      directed_table.push_back({32'hFE31_3FA3, PREDICTED, BLANK_DECODE});
      directed_table.push_back({32'h7E31_0FA3, PREDICTED, BLANK_DECODE});
      // branches: beq -4096, funct3 010 and 011
      directed_table.push_back({32'h8000_0063, PREDICTED, BLANK_DECODE});
      directed_table.push_back({32'h0000_2063, PREDICTED, BLANK_DECODE});
      directed_table.push_back({32'h0000_3063, PREDICTED, BLANK_DECODE});
      // lui with every immediate bit set
      directed_table.push_back({32'hFFFF_F0B7, LITERAL,
         {64'hFFFF_FFFF_FFFF_F000, ALU_PASS, 1'b1, 1'b1, WB_ALU, 1'b1,
          MEM_NONE, SIZE_BYTE, NPC_SEQ, EXC_NONE}});
      directed_table.push_back({32'h8000_0097, PREDICTED, BLANK_DECODE});   // auipc
      directed_table.push_back({32'h8000_00EF, PREDICTED, BLANK_DECODE});   // jal, most negative
      directed_table.push_back({32'hFFF0_8067, PREDICTED, BLANK_DECODE});   // jalr -1
      // SYSTEM: ecall, ebreak, ecall with junk fields, immediate 2
      directed_table.push_back({32'h0000_0073, LITERAL,
         {64'sd0, ALU_PASS, 1'b0, 1'b1, WB_ALU, 1'b0,
          MEM_NONE, SIZE_BYTE, NPC_SEQ, EXC_ECALL}});
      directed_table.push_back({32'h0010_0073, LITERAL,
         {64'sd1, ALU_PASS, 1'b0, 1'b1, WB_ALU, 1'b0,
          MEM_NONE, SIZE_BYTE, NPC_SEQ, EXC_EBREAK}});
      directed_table.push_back({32'h000F_FFF3, PREDICTED, BLANK_DECODE});
      directed_table.push_back({32'h0020_0073, PREDICTED, BLANK_DECODE});

      @(posedge clock);
      while (reset) @(posedge clock);

      foreach (directed_table[i]) begin
         row = directed_table[i];
         offer(row.word, row.literal ? row.result : decode_word(row.word), 1'b1);
      end
      drain();

      for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
         w = random_word();
         // every 200 words, a burst of 40 with no sender gaps
         offer(w, decode_word(w), (n % 200) >= 40);
         if (n == DRAIN_AT) drain();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_decodes.size() != 0) begin
         $display("%0t: %0d decodes never returned", $time, pending_decodes.size());
         errors++;
      end

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: alternating ready and stall stretches, with one long hold-off
   // once the run is under way so the pipeline backs up into req_ready.
   // ------------------------------------------------------------------
   int unsigned rx_left = 0;
   logic        rx_stalled = 1'b0;
   logic        hold_off_done = 1'b0;

   always @(posedge clock) begin
      if (!hold_off_done && words_accepted >= HOLD_OFF_AT) begin
         hold_off_done = 1'b1;
         rx_stalled    = 1'b1;
         rx_left       = HOLD_OFF_CYCLES;
      end else if (rx_left == 0) begin
         rx_stalled = !rx_stalled;
         if (rx_stalled)
            rx_left = idle_length(1);
         else
            rx_left = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                                   : $urandom_range(30, 120);
      end else begin
         rx_left = rx_left - 1;
      end
      rsp_ready <= !rx_stalled;
   end

   // ------------------------------------------------------------------
   // Scoreboard: match each rsp transaction against the oldest pending decode
   // ------------------------------------------------------------------
   task automatic check_field(input logic [31:0] word, input string name,
                              input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: word %h %s expected %h got %h", $time, word, name, want, got);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      stim_row_type head;
      decode_type   want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_decodes.size() == 0) begin
               errors++;
               $display("%0t: decode with none pending, imm %h", $time, rsp_immediate_value);
            end else begin
               head = pending_decodes.pop_front();
               want = head.result;
               check_field(head.word, "immediate_value", want.immediate_value,
                           rsp_immediate_value);
               check_field(head.word, "alu_operation", want.alu_operation,
                           rsp_alu_operation);
               check_field(head.word, "operand_a_is_pc", want.operand_a_is_pc,
                           rsp_operand_a_is_pc);
               check_field(head.word, "operand_b_is_imm", want.operand_b_is_imm,
                           rsp_operand_b_is_imm);
               check_field(head.word, "writeback_source", want.writeback_source,
                           rsp_writeback_source);
               check_field(head.word, "register_write", want.register_write,
                           rsp_register_write);
               check_field(head.word, "mem_kind", want.mem_kind, rsp_mem_kind);
               check_field(head.word, "access_size", want.access_size, rsp_access_size);
               check_field(head.word, "next_pc_source", want.next_pc_source,
                           rsp_next_pc_source);
               check_field(head.word, "trap_kind", want.trap_kind, rsp_trap_kind);
            end
         end
         if (req_valid && req_ready)
            pending_decodes.push_back({req_instruction_word, PREDICTED, req_decode});
         // shared counters move on the NBA region so other processes read them cleanly
         words_accepted    <= words_accepted + ((req_valid && req_ready) ? 1 : 0);
         decodes_in_flight <= pending_decodes.size();
      end
   end

endmodule
